// ----- rtl/tcf_pkg.sv -----
// Shared constants, transaction types and tables for the timestamp to calendar converter.
package tcf_pkg;

   // Timestamp limits
   localparam logic [63:0] FT_OFFSET = 64'd116444736000000000;
   localparam logic [63:0] US_LIMIT  = 64'd4102444800000000;
   localparam logic [63:0] FT_LIMIT  = 64'd157469184000000000;

   // Seconds divider geometry: one quotient byte per digit, two stages per digit
   localparam int DIV_REM_W   = 24;
   localparam int DIV_QUO_W   = 32;
   localparam int DIV_DIGIT_W = 8;
   localparam int DIV_DIGITS  = DIV_QUO_W / DIV_DIGIT_W;
   localparam logic [DIV_REM_W-1:0] US_DIVISOR = 24'd1000000;
   localparam logic [DIV_REM_W-1:0] FT_DIVISOR = 24'd10000000;

   // Quotient digit estimate: 1e6 = 2^6 * 15625, 1e7 = 2^7 * 78125, then q = (x * M) >> SH
   localparam int                    US_DIV_SHIFT = 6;
   localparam int                    FT_DIV_SHIFT = 7;
   localparam int                    DIV_RECIP_W  = 29;
   localparam int                    DIV_RECIP_SH = 42;
   localparam logic [DIV_RECIP_W-1:0] US_RECIP    = 29'd281474977;
   localparam logic [DIV_RECIP_W-1:0] FT_RECIP    = 29'd56294996;

   // Reciprocals for constant division: q = (x * M) >> SH
   localparam logic [25:0] M675  = 26'd50903317;
   localparam int          SH675 = 35;
   localparam logic [31:0] M10   = 32'hCCCCCCCD;
   localparam int          SH10  = 35;
   localparam logic [16:0] M1461 = 17'd91868;
   localparam int          SH1461 = 27;
   localparam logic [20:0] M1000 = 21'd1073742;
   localparam int          SH1000 = 30;
   localparam logic [17:0] M3600 = 18'd149131;
   localparam int          SH3600 = 29;
   localparam logic [12:0] M60   = 13'd4370;
   localparam int          SH60  = 18;

   // Calendar constants
   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
   localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [9:0]  SUB_PER_UNIT  = 10'd1000;
   localparam logic [11:0] BASE_YEAR_M1  = 12'd1969;
   localparam int          MONTHS        = 12;

   // Seconds divider transaction: word holds dividend bits, then quotient bits
   typedef struct packed {
      logic                 func;
      logic                 out_of_range;
      logic [DIV_REM_W-1:0] rem;
      logic [DIV_QUO_W-1:0] word;
   } div_item_type;

   // Calendar transaction handed to the output stage
   typedef struct packed {
      logic        out_of_range;
      logic [11:0] year;
      logic        leap;
      logic [3:0]  month;
      logic [8:0]  doy0;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [11:0] ts;
      logic [9:0]  millisecond;
      logic [9:0]  microsecond;
   } cal_item_type;

   // Days before each month in a common year
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] days;
      unique case (idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ----- rtl/tcf_front.sv -----
// Input register, range check and dividend preparation for the seconds divider.
module tcf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [63:0]                req_time_value,
   input  logic                       down_load,
   output logic                       out_valid,
   output tcf_pkg::div_item_type      out_item
);

   logic                  in_valid_ff;
   logic                  in_func_ff;
   logic [63:0]           in_time_ff;
   logic                  prep_valid_ff;
   tcf_pkg::div_item_type prep_ff;
   tcf_pkg::div_item_type prep_in;
   logic                  in_load;
   logic                  prep_load;
   logic                  out_of_range;
   logic [63:0]           ft_diff;
   logic [55:0]           dividend;

   // Each stage loads when empty or when its contents move on
   assign prep_load = !prep_valid_ff || down_load;
   assign in_load   = !in_valid_ff || prep_load;
   assign req_ready = in_load;

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_func_ff <= req_func;
         in_time_ff <= req_time_value;
      end
   end

   // Check the span and form the dividend; file time is divided by 1e7 directly
   always_comb begin
      ft_diff = in_time_ff - tcf_pkg::FT_OFFSET;
      if (in_func_ff) begin
         out_of_range = (in_time_ff < tcf_pkg::FT_OFFSET) || (in_time_ff >= tcf_pkg::FT_LIMIT);
      end else begin
         out_of_range = in_time_ff >= tcf_pkg::US_LIMIT;
      end
      if (out_of_range) begin
         dividend = 56'd0;
      end else if (in_func_ff) begin
         dividend = ft_diff[55:0];
      end else begin
         dividend = in_time_ff[55:0];
      end
      prep_in.func         = in_func_ff;
      prep_in.out_of_range = out_of_range;
      prep_in.rem          = dividend[55:32];
      prep_in.word         = dividend[31:0];
   end

   // Hold the prepared dividend
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_load) begin
         prep_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_load) begin
         prep_ff <= prep_in;
      end
   end

   assign out_valid = prep_valid_ff;
   assign out_item  = prep_ff;

endmodule

// ----- rtl/tcf_sec_div.sv -----
// Pipelined constant divider: microseconds or file time units to whole seconds, one quotient byte every two stages.
module tcf_sec_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tcf_pkg::div_item_type in_item,
   output logic                  up_load,
   input  logic                  down_load,
   output logic                  out_valid,
   output tcf_pkg::div_item_type out_item
);

   localparam int DIGITS   = tcf_pkg::DIV_DIGITS;
   localparam int DIGIT_W  = tcf_pkg::DIV_DIGIT_W;
   localparam int REM_W    = tcf_pkg::DIV_REM_W;
   localparam int QUO_W    = tcf_pkg::DIV_QUO_W;
   localparam int PART_W   = REM_W + DIGIT_W;
   localparam int SCALED_W = PART_W - tcf_pkg::US_DIV_SHIFT;
   localparam int RECIP_W  = tcf_pkg::DIV_RECIP_W;
   localparam int PROD_W   = SCALED_W + RECIP_W;

   // Partial dividend, with the estimated quotient byte already shifted into word
   typedef struct packed {
      logic              func;
      logic              out_of_range;
      logic [PART_W-1:0] part;
      logic [QUO_W-1:0]  word;
   } est_type;

   logic [DIGITS-1:0]     est_valid_ff;
   logic [DIGITS-1:0]     rem_valid_ff;
   logic [DIGITS-1:0]     rem_load;
   logic [DIGITS:0]       pass_load;
   logic [DIGITS-1:0]     src_valid;
   est_type               est_ff [DIGITS];
   est_type               est_in [DIGITS];
   tcf_pkg::div_item_type rem_ff [DIGITS];
   tcf_pkg::div_item_type rem_in [DIGITS];
   tcf_pkg::div_item_type src_item [DIGITS];
   logic [PART_W-1:0]     part;
   logic [SCALED_W-1:0]   scaled;
   logic [RECIP_W-1:0]    recip;
   logic [PROD_W-1:0]     est_prod;
   logic [REM_W-1:0]      divisor;
   logic [PART_W-1:0]     back_prod;

   // Load chain: a stage takes new data when empty or when its contents move on
   always_comb begin
      pass_load[DIGITS] = down_load;
      for (int k = DIGITS - 1; k >= 0; k--) begin
         rem_load[k]  = !rem_valid_ff[k] || pass_load[k+1];
         pass_load[k] = !est_valid_ff[k] || rem_load[k];
      end
   end

   // Feed each digit from the one before it
   always_comb begin
      src_item[0]  = in_item;
      src_valid[0] = in_valid;
      for (int k = 1; k < DIGITS; k++) begin
         src_item[k]  = rem_ff[k-1];
         src_valid[k] = rem_valid_ff[k-1];
      end
   end

   // Estimate one quotient byte: drop the power of two, multiply by the reciprocal
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         part = {src_item[k].rem, src_item[k].word[QUO_W-1 -: DIGIT_W]};
         if (src_item[k].func) begin
            scaled = SCALED_W'(part >> tcf_pkg::FT_DIV_SHIFT);
            recip  = tcf_pkg::FT_RECIP;
         end else begin
            scaled = SCALED_W'(part >> tcf_pkg::US_DIV_SHIFT);
            recip  = tcf_pkg::US_RECIP;
         end
         est_prod = PROD_W'(scaled) * PROD_W'(recip);
         est_in[k].func         = src_item[k].func;
         est_in[k].out_of_range = src_item[k].out_of_range;
         est_in[k].part         = part;
         est_in[k].word         = {src_item[k].word[QUO_W-DIGIT_W-1:0],
                                   est_prod[tcf_pkg::DIV_RECIP_SH +: DIGIT_W]};
      end
   end

   // Form the remainder left after the quotient byte
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         divisor   = est_ff[k].func ? tcf_pkg::FT_DIVISOR : tcf_pkg::US_DIVISOR;
         back_prod = PART_W'(est_ff[k].word[DIGIT_W-1:0]) * PART_W'(divisor);
         rem_in[k].func         = est_ff[k].func;
         rem_in[k].out_of_range = est_ff[k].out_of_range;
         rem_in[k].rem          = REM_W'(est_ff[k].part - back_prod);
         rem_in[k].word         = est_ff[k].word;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff <= '0;
         rem_valid_ff <= '0;
      end else begin
         for (int k = 0; k < DIGITS; k++) begin
            if (pass_load[k]) est_valid_ff[k] <= src_valid[k];
            if (rem_load[k])  rem_valid_ff[k] <= est_valid_ff[k];
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIGITS; k++) begin
         if (pass_load[k]) est_ff[k] <= est_in[k];
         if (rem_load[k])  rem_ff[k] <= rem_in[k];
      end
   end

   assign up_load   = pass_load[0];
   assign out_valid = rem_valid_ff[DIGITS-1];
   assign out_item  = rem_ff[DIGITS-1];

endmodule

// ----- rtl/tcf_calendar.sv -----
// Calendar split: seconds to days and time of day, days to year, month and day of year.
module tcf_calendar (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tcf_pkg::div_item_type in_item,
   output logic                  up_load,
   input  logic                  down_load,
   output logic                  out_valid,
   output tcf_pkg::cal_item_type out_item
);

   localparam logic [10:0] YEAR1_START = 11'd365;
   localparam logic [10:0] YEAR2_START = 11'd730;
   localparam logic [10:0] YEAR3_START = 11'd1095;

   typedef struct packed {
      logic        oor;
      logic [15:0] days;
      logic [16:0] secs_lo;
      logic [19:0] sub_us;
   } c1_type;

   typedef struct packed {
      logic        oor;
      logic [16:0] tod;
      logic [15:0] shifted;
      logic [5:0]  quad;
      logic [19:0] sub_us;
      logic [9:0]  ms;
   } c2_type;

   typedef struct packed {
      logic        oor;
      logic [16:0] tod;
      logic [4:0]  hour;
      logic [10:0] qrem;
      logic [5:0]  quad;
      logic [9:0]  ms;
      logic [9:0]  usec;
   } c3_type;

   typedef struct packed {
      logic        oor;
      logic [11:0] ts;
      logic [4:0]  hour;
      logic [8:0]  doy0;
      logic [11:0] year;
      logic        leap;
      logic [9:0]  ms;
      logic [9:0]  usec;
   } c4_type;

   c1_type                c1_ff, c1_in;
   c2_type                c2_ff, c2_in;
   c3_type                c3_ff, c3_in;
   c4_type                c4_ff, c4_in;
   tcf_pkg::cal_item_type c5_ff, c5_in;
   logic                  c1_valid_ff, c2_valid_ff, c3_valid_ff, c4_valid_ff, c5_valid_ff;
   logic                  c1_load, c2_load, c3_load, c4_load, c5_load;

   logic [50:0] days_prod;
   logic [55:0] frac_prod;
   logic [32:0] day_secs;
   logic [32:0] quad_prod;
   logic [40:0] ms_prod;
   logic [34:0] hour_prod;
   logic [16:0] quad_days;
   logic [19:0] ms_us;
   logic [16:0] hour_secs;
   logic [1:0]  yiq;
   logic [10:0] year_base;
   logic [11:0] year_sum;
   logic [24:0] min_prod;
   logic [3:0]  month_cnt;
   logic [8:0]  start_day;

   // Load chain: a stage takes new data when empty or draining
   assign c5_load = !c5_valid_ff || down_load;
   assign c4_load = !c4_valid_ff || c5_load;
   assign c3_load = !c3_valid_ff || c4_load;
   assign c2_load = !c2_valid_ff || c3_load;
   assign c1_load = !c1_valid_ff || c2_load;
   assign up_load = c1_load;

   // Stage 1: whole days, sub-second microseconds
   always_comb begin
      days_prod     = 51'(in_item.word[31:7]) * 51'(tcf_pkg::M675);
      frac_prod     = 56'(in_item.rem) * 56'(tcf_pkg::M10);
      c1_in.oor     = in_item.out_of_range;
      c1_in.days    = days_prod[tcf_pkg::SH675 +: 16];
      c1_in.secs_lo = in_item.word[16:0];
      c1_in.sub_us  = in_item.func ? frac_prod[tcf_pkg::SH10 +: 20] : in_item.rem[19:0];
   end

   // Stage 2: time of day, four-year group, milliseconds
   always_comb begin
      day_secs      = 33'(c1_ff.days) * 33'(tcf_pkg::SEC_PER_DAY);
      c2_in.oor     = c1_ff.oor;
      c2_in.tod     = c1_ff.secs_lo - day_secs[16:0];
      c2_in.shifted = c1_ff.days + 16'(tcf_pkg::DAYS_PER_YEAR);
      quad_prod     = 33'(c2_in.shifted) * 33'(tcf_pkg::M1461);
      c2_in.quad    = quad_prod[tcf_pkg::SH1461 +: 6];
      ms_prod       = 41'(c1_ff.sub_us) * 41'(tcf_pkg::M1000);
      c2_in.ms      = ms_prod[tcf_pkg::SH1000 +: 10];
      c2_in.sub_us  = c1_ff.sub_us;
   end

   // Stage 3: hour, day within the group, microseconds
   always_comb begin
      hour_prod  = 35'(c2_ff.tod) * 35'(tcf_pkg::M3600);
      quad_days  = 17'(c2_ff.quad) * 17'(tcf_pkg::DAYS_PER_QUAD);
      ms_us      = 20'(c2_ff.ms) * 20'(tcf_pkg::SUB_PER_UNIT);
      c3_in.oor  = c2_ff.oor;
      c3_in.tod  = c2_ff.tod;
      c3_in.hour = hour_prod[tcf_pkg::SH3600 +: 5];
      c3_in.qrem = c2_ff.shifted[10:0] - quad_days[10:0];
      c3_in.quad = c2_ff.quad;
      c3_in.ms   = c2_ff.ms;
      c3_in.usec = c2_ff.sub_us[9:0] - ms_us[9:0];
   end

   // Stage 4: seconds within the hour, year and zero-based day of year
   always_comb begin
      hour_secs = 17'(c3_ff.hour) * 17'(tcf_pkg::SEC_PER_HOUR);
      priority if (c3_ff.qrem >= YEAR3_START) begin
         yiq       = 2'd3;
         year_base = YEAR3_START;
      end else if (c3_ff.qrem >= YEAR2_START) begin
         yiq       = 2'd2;
         year_base = YEAR2_START;
      end else if (c3_ff.qrem >= YEAR1_START) begin
         yiq       = 2'd1;
         year_base = YEAR1_START;
      end else begin
         yiq       = 2'd0;
         year_base = 11'd0;
      end
      year_sum   = tcf_pkg::BASE_YEAR_M1 + {4'd0, c3_ff.quad, 2'b00} + {10'd0, yiq};
      c4_in.oor  = c3_ff.oor;
      c4_in.ts   = c3_ff.tod[11:0] - hour_secs[11:0];
      c4_in.hour = c3_ff.hour;
      c4_in.doy0 = 9'(c3_ff.qrem - year_base);
      c4_in.year = year_sum;
      c4_in.leap = year_sum[1:0] == 2'b00;
      c4_in.ms   = c3_ff.ms;
      c4_in.usec = c3_ff.usec;
   end

   // Stage 5: minute and month
   always_comb begin
      min_prod  = 25'(c4_ff.ts) * 25'(tcf_pkg::M60);
      month_cnt = 4'd1;
      for (int i = 1; i < tcf_pkg::MONTHS; i++) begin
         start_day = tcf_pkg::month_start(4'(i)) + {8'd0, c4_ff.leap && (i >= 2)};
         if (c4_ff.doy0 >= start_day) begin
            month_cnt = 4'(i + 1);
         end
      end
      c5_in.out_of_range = c4_ff.oor;
      c5_in.year         = c4_ff.year;
      c5_in.leap         = c4_ff.leap;
      c5_in.month        = month_cnt;
      c5_in.doy0         = c4_ff.doy0;
      c5_in.hour         = c4_ff.hour;
      c5_in.minute       = min_prod[tcf_pkg::SH60 +: 6];
      c5_in.ts           = c4_ff.ts;
      c5_in.millisecond  = c4_ff.ms;
      c5_in.microsecond  = c4_ff.usec;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
         c4_valid_ff <= 1'b0;
         c5_valid_ff <= 1'b0;
      end else begin
         if (c1_load) c1_valid_ff <= in_valid;
         if (c2_load) c2_valid_ff <= c1_valid_ff;
         if (c3_load) c3_valid_ff <= c2_valid_ff;
         if (c4_load) c4_valid_ff <= c3_valid_ff;
         if (c5_load) c5_valid_ff <= c4_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (c1_load) c1_ff <= c1_in;
      if (c2_load) c2_ff <= c2_in;
      if (c3_load) c3_ff <= c3_in;
      if (c4_load) c4_ff <= c4_in;
      if (c5_load) c5_ff <= c5_in;
   end

   assign out_valid = c5_valid_ff;
   assign out_item  = c5_ff;

endmodule

// ----- rtl/timestamp_to_calendar_fields.sv -----
// A transaction accepted into the input register moves through every stage in order to rsp_valid.
// Throughput: one transaction per cycle while not stalled; every stage holds one transaction.
// Depth: two front stages, eight divider stages, five calendar stages and the output register.
// A stalled result holds the output register; upstream stages keep filling until all are full.
// Reset (synchronous) clears every valid bit; payload registers are not reset.
module timestamp_to_calendar_fields (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [63:0] req_time_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [8:0]  rsp_day_of_year,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [9:0]  rsp_millisecond,
   output logic [9:0]  rsp_microsecond,
   output logic        rsp_out_of_range
);

   tcf_pkg::div_item_type front_item;
   tcf_pkg::div_item_type div_item;
   tcf_pkg::cal_item_type cal_item;
   logic                  front_valid, div_valid, cal_valid;
   logic                  div_load, cal_load, out_load;

   logic        rsp_valid_ff;
   logic [11:0] rsp_year_ff, rsp_year_in;
   logic [3:0]  rsp_month_ff, rsp_month_in;
   logic [4:0]  rsp_day_ff, rsp_day_in;
   logic [8:0]  rsp_day_of_year_ff, rsp_day_of_year_in;
   logic [4:0]  rsp_hour_ff, rsp_hour_in;
   logic [5:0]  rsp_minute_ff, rsp_minute_in;
   logic [5:0]  rsp_second_ff, rsp_second_in;
   logic [9:0]  rsp_millisecond_ff, rsp_millisecond_in;
   logic [9:0]  rsp_microsecond_ff, rsp_microsecond_in;
   logic        rsp_out_of_range_ff;

   logic [11:0] min_secs;
   logic [8:0]  month_base;

   tcf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_time_value (req_time_value),
      .down_load      (div_load),
      .out_valid      (front_valid),
      .out_item       (front_item)
   );

   tcf_sec_div u_sec_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .up_load   (div_load),
      .down_load (cal_load),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   tcf_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_item   (div_item),
      .up_load   (cal_load),
      .down_load (out_load),
      .out_valid (cal_valid),
      .out_item  (cal_item)
   );

   assign out_load = !rsp_valid_ff || rsp_ready;

   // Final fields: second, day of month; zero everything out of range
   always_comb begin
      min_secs   = 12'(cal_item.minute) * 12'(tcf_pkg::SEC_PER_MIN);
      month_base = tcf_pkg::month_start(cal_item.month - 4'd1)
                   + {8'd0, cal_item.leap && (cal_item.month >= 4'd3)};
      if (cal_item.out_of_range) begin
         rsp_year_in        = 12'd0;
         rsp_month_in       = 4'd0;
         rsp_day_in         = 5'd0;
         rsp_day_of_year_in = 9'd0;
         rsp_hour_in        = 5'd0;
         rsp_minute_in      = 6'd0;
         rsp_second_in      = 6'd0;
         rsp_millisecond_in = 10'd0;
         rsp_microsecond_in = 10'd0;
      end else begin
         rsp_year_in        = cal_item.year;
         rsp_month_in       = cal_item.month;
         rsp_day_in         = 5'(cal_item.doy0 - month_base + 9'd1);
         rsp_day_of_year_in = cal_item.doy0 + 9'd1;
         rsp_hour_in        = cal_item.hour;
         rsp_minute_in      = cal_item.minute;
         rsp_second_in      = cal_item.ts[5:0] - min_secs[5:0];
         rsp_millisecond_in = cal_item.millisecond;
         rsp_microsecond_in = cal_item.microsecond;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= cal_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_year_ff         <= rsp_year_in;
         rsp_month_ff        <= rsp_month_in;
         rsp_day_ff          <= rsp_day_in;
         rsp_day_of_year_ff  <= rsp_day_of_year_in;
         rsp_hour_ff         <= rsp_hour_in;
         rsp_minute_ff       <= rsp_minute_in;
         rsp_second_ff       <= rsp_second_in;
         rsp_millisecond_ff  <= rsp_millisecond_in;
         rsp_microsecond_ff  <= rsp_microsecond_in;
         rsp_out_of_range_ff <= cal_item.out_of_range;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day          = rsp_day_ff;
   assign rsp_day_of_year  = rsp_day_of_year_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_second       = rsp_second_ff;
   assign rsp_millisecond  = rsp_millisecond_ff;
   assign rsp_microsecond  = rsp_microsecond_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

`ifndef ASSERT_OFF
   // Out-of-range transactions carry no date
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_year == 12'd0 && rsp_month == 4'd0 &&
      rsp_day == 5'd0 && rsp_day_of_year == 9'd0)
      else $error("out-of-range result carries a non-zero date");

   // In-range dates stay inside the supported calendar
   a_date_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> rsp_year >= 12'd1970 && rsp_year <= 12'd2099 &&
      rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1 &&
      rsp_day_of_year >= 9'd1 && rsp_day_of_year <= 9'd366)
      else $error("date field outside calendar bounds");

   // Day 366 is always the last of December
   a_leap_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range && rsp_day_of_year == 9'd366 |->
      rsp_month == 4'd12 && rsp_day == 5'd31)
      else $error("day 366 not mapped to 31 December");

   // Time of day fields stay in range
   a_time_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59 &&
      rsp_millisecond <= 10'd999 && rsp_microsecond <= 10'd999)
      else $error("time of day field out of range");

   // Input back-pressure only when the pipeline is full behind a stalled result
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- test/timestamp_to_calendar_fields_checker.sv -----
// Checker for the timestamp to calendar converter: predicts each conversion and compares results.
module timestamp_to_calendar_fields_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [63:0] req_time_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [11:0] rsp_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day,
   input  logic [8:0]  rsp_day_of_year,
   input  logic [4:0]  rsp_hour,
   input  logic [5:0]  rsp_minute,
   input  logic [5:0]  rsp_second,
   input  logic [9:0]  rsp_millisecond,
   input  logic [9:0]  rsp_microsecond,
   input  logic        rsp_out_of_range,
   output int          failures,
   output int          pending_dates,
   output int          dates_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // File time of 1970-01-01 and the first microsecond of 2100
   localparam logic [63:0] FILETIME_AT_1970 = 64'd116444736000000000;
   localparam logic [63:0] US_AT_2100       = 64'd4102444800000000;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  millisecond;
      logic [9:0]  microsecond;
      logic        out_of_range;
   } calendar_type;

   calendar_type expected_dates[$];
   int           fail_total = 0;
   int           checked_total = 0;

   function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
      case (mon)
         4, 6, 9, 11: return 30;
         2:           return (yr % 4 == 0) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   // Walk whole years, then whole months, from 1970 onwards
   function automatic calendar_type calendar_of(input logic func, input logic [63:0] stamp);
      calendar_type c;
      logic [63:0]  us;
      logic [63:0]  secs;
      logic [63:0]  tod;
      int unsigned  rest;
      int unsigned  yr;
      int unsigned  mon;
      c = '0;
      if (func && stamp < FILETIME_AT_1970) begin
         c.out_of_range = 1'b1;
         return c;
      end
      us = func ? (stamp - FILETIME_AT_1970) / 64'd10 : stamp;
      if (us >= US_AT_2100) begin
         c.out_of_range = 1'b1;
         return c;
      end
      secs = us / 64'd1000000;
      tod  = secs % 64'd86400;
      rest = 32'(secs / 64'd86400);
      yr   = 1970;
      while (rest >= ((yr % 4 == 0) ? 366 : 365)) begin
         rest -= (yr % 4 == 0) ? 366 : 365;
         yr++;
      end
      c.year        = yr[11:0];
      c.day_of_year = 9'(rest + 1);
      mon = 1;
      while (rest >= month_length(mon, yr)) begin
         rest -= month_length(mon, yr);
         mon++;
      end
      c.month       = mon[3:0];
      c.day         = 5'(rest + 1);
      c.hour        = 5'(tod / 3600);
      c.minute      = 6'((tod % 3600) / 60);
      c.second      = 6'(tod % 60);
      c.millisecond = 10'((us / 1000) % 1000);
      c.microsecond = 10'(us % 1000);
      return c;
   endfunction

   function automatic string describe(input calendar_type c);
      return $sformatf("%0d-%0d-%0d doy %0d %0d:%0d:%0d ms %0d us %0d oor %0d",
                       c.year, c.month, c.day, c.day_of_year, c.hour, c.minute,
                       c.second, c.millisecond, c.microsecond, c.out_of_range);
   endfunction

   calendar_type seen;
   assign seen = '{rsp_year, rsp_month, rsp_day, rsp_day_of_year, rsp_hour, rsp_minute,
                   rsp_second, rsp_millisecond, rsp_microsecond, rsp_out_of_range};

   always @(posedge clock) begin
      if (!reset) begin
         // Compare a delivered result against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_dates.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected result %s", $realtime, describe(seen));
            end else begin
               calendar_type want;
               want = expected_dates.pop_front();
               checked_total++;
               if (seen !== want) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("%0t: mismatch, expected %s, got %s",
                              $realtime, describe(want), describe(seen));
               end
            end
         end
         // Predict every accepted request
         if (req_valid && req_ready)
            expected_dates.push_back(calendar_of(req_func, req_time_value));
      end
      failures      <= fail_total;
      pending_dates <= expected_dates.size();
      dates_checked <= checked_total;
   end

endmodule

// ----- test/timestamp_to_calendar_fields_test.sv -----
// Top of the timestamp to calendar converter testbench: clock, reset, stimulus and verdict.
module timestamp_to_calendar_fields_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] FILETIME_AT_1970 = 64'd116444736000000000;
   localparam logic [63:0] US_AT_2100       = 64'd4102444800000000;
   localparam logic [63:0] FILETIME_AT_2100 = 64'd157469184000000000;
   localparam int          CYCLE_LIMIT      = 400000;
   localparam int          HOLD_CYCLES      = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [63:0] req_time_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [8:0]  rsp_day_of_year;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [9:0]  rsp_millisecond;
   logic [9:0]  rsp_microsecond;
   logic        rsp_out_of_range;

   int   failures;
   int   pending_dates;
   int   dates_checked;
   int   cycle_count = 0;
   int   sent_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_go = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   always #5 clock = ~clock;

   timestamp_to_calendar_fields u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_day_of_year  (rsp_day_of_year),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_millisecond  (rsp_millisecond),
      .rsp_microsecond  (rsp_microsecond),
      .rsp_out_of_range (rsp_out_of_range)
   );

   timestamp_to_calendar_fields_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_day_of_year  (rsp_day_of_year),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_millisecond  (rsp_millisecond),
      .rsp_microsecond  (rsp_microsecond),
      .rsp_out_of_range (rsp_out_of_range),
      .failures         (failures),
      .pending_dates    (pending_dates),
      .dates_checked    (dates_checked)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[timestamp_to_calendar_fields] ERROR");
         $finish;
      end
   end

   // Drive the result side: one long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic int month_days(input int mon, input int yr);
      case (mon)
         4, 6, 9, 11: return 30;
         2:           return (yr % 4 == 0) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   // Microseconds since 1970 for a calendar date and time of day
   function automatic logic [63:0] unix_us(input int yr, input int mon, input int dom,
                                           input int hr, input int mi, input int sec,
                                           input int sub_us);
      logic [63:0] days;
      days = 64'((yr - 1970) * 365 + (yr - 1969) / 4 + dom - 1);
      for (int m = 1; m < mon; m++)
         days += 64'(month_days(m, yr));
      return (days * 64'd86400 + 64'(hr * 3600 + mi * 60 + sec)) * 64'd1000000 + 64'(sub_us);
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_stamp(input logic func, input logic [63:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_time_value <= stamp;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic send_unix(input logic func, input logic [63:0] us);
      send_stamp(func, func ? FILETIME_AT_1970 + us * 64'd10 + 64'($urandom_range(9)) : us);
   endtask

   // Mostly calendar boundaries and well-formed stamps, some range edges and noise
   task automatic send_random_stamp();
      int          pick;
      int          yr;
      int          mon;
      int          dom;
      logic        func;
      logic [63:0] us;
      pick = $urandom_range(99);
      func = 1'($urandom_range(1));
      if (pick < 35) begin
         us = {$urandom, $urandom} % US_AT_2100;
         send_unix(func, us);
      end else if (pick < 75) begin
         yr  = $urandom_range(2099, 1970);
         mon = $urandom_range(12, 1);
         dom = $urandom_range(1) ? month_days(mon, yr) : 1;
         if ($urandom_range(3) == 0)
            dom = $urandom_range(month_days(mon, yr), 1);
         case ($urandom_range(2))
            0:       us = unix_us(yr, mon, dom, 23, 59, 59, $urandom_range(999999, 999000));
            1:       us = unix_us(yr, mon, dom, 0, 0, 0, $urandom_range(999));
            default: us = unix_us(yr, mon, dom, $urandom_range(23), $urandom_range(59),
                                  $urandom_range(59), $urandom_range(999999));
         endcase
         send_unix(func, us);
      end else if (pick < 90) begin
         case ($urandom_range(2))
            0:       send_stamp(1'b0, US_AT_2100 - 64'd1000 + 64'($urandom_range(1999)));
            1:       send_stamp(1'b1, FILETIME_AT_1970 - 64'd20 + 64'($urandom_range(39)));
            default: send_stamp(1'b1, FILETIME_AT_2100 - 64'd20 + 64'($urandom_range(39)));
         endcase
      end else begin
         send_stamp(func, {$urandom, $urandom});
      end
   endtask

   task automatic wait_for_dates();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_dates != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count)
         send_random_stamp();
      wait_for_dates();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: range edges in both modes, leap days and day extremes
      send_stamp(1'b0, 64'd0);
      send_stamp(1'b0, 64'd1);
      send_stamp(1'b0, US_AT_2100 - 64'd1);
      send_stamp(1'b0, US_AT_2100);
      send_stamp(1'b0, '1);
      send_stamp(1'b1, '1);
      send_stamp(1'b1, 64'd0);
      send_stamp(1'b1, FILETIME_AT_1970 - 64'd1);
      send_stamp(1'b1, FILETIME_AT_1970);
      send_stamp(1'b1, FILETIME_AT_1970 + 64'd9);
      send_stamp(1'b1, FILETIME_AT_1970 + 64'd10);
      send_stamp(1'b1, FILETIME_AT_2100 - 64'd1);
      send_stamp(1'b1, FILETIME_AT_2100);
      send_stamp(1'b0, unix_us(1971, 2, 28, 23, 59, 59, 999999));
      send_stamp(1'b0, unix_us(1972, 2, 29, 12, 30, 30, 500500));
      send_stamp(1'b0, unix_us(1972, 3, 1, 0, 0, 0, 0));
      send_stamp(1'b0, unix_us(1972, 12, 31, 23, 59, 59, 999999));
      send_stamp(1'b0, unix_us(1973, 1, 1, 0, 0, 0, 0));
      send_stamp(1'b1, FILETIME_AT_1970 + unix_us(2096, 12, 31, 18, 0, 0, 0) * 64'd10 + 64'd5);
      send_stamp(1'b0, unix_us(2099, 12, 31, 0, 0, 0, 1));
      wait_for_dates();

      // Random phases across sender idling and receiver stalls
      run_phase(0, 0, 275);
      run_phase(64, 0, 275);
      run_phase(0, 64, 275);
      run_phase(8, 8, 275);

      // Hold the receiver off while streaming so the pipeline fills and stalls input
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go <= 1'b1;
      repeat (48)
         send_random_stamp();
      wait_for_dates();

      repeat (20) @(posedge clock);
      $display("Converted %0d timestamps in both modes over idle, stall and back-pressure phases.",
               sent_count);
      $display("Checked %0d calendar results, %0d failures.", dates_checked, failures);
      if (failures == 0 && pending_dates == 0) begin
         $display("[timestamp_to_calendar_fields] OK");
      end else begin
         $display("[timestamp_to_calendar_fields] ERROR");
      end
      $finish;
   end

endmodule
